/* hw/rtl/sma_pkg.sv */
`default_nettype none

package sma_pkg;

    localparam int DATA_W = 32;
    localparam int LEN_REG_W = 7;
    localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd8;

    // operation field codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FILL = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_SUM,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

/* hw/rtl/sma_in_if.sv */
`default_nettype none

interface sma_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic signed [sma_pkg::DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sma_out_if.sv */
`default_nettype none

interface sma_out_if;
    logic valid;
    logic ready;
    logic signed [sma_pkg::DATA_W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink (input valid, input average, output ready);
endinterface

`default_nettype wire

/* hw/rtl/moving_average_filter.sv */
`default_nettype none

// Simple moving average over a window of window_length signed 32-bit samples
// (register at byte address 0; 0 acts as 1, values above MAX_WINDOW act as
// MAX_WINDOW). A sample transaction writes the oldest slot of the store and
// returns the window sum divided by the length, truncated toward zero; a fill
// transaction loads the first window_length slots with its value, resets the
// write position and returns nothing. After reset every slot of the store is
// cleared to zero, and no item is accepted until that is done (register writes are).
// For a sample, the window of L entries (L is the window length) is read back
// one entry per cycle through the single store read port into a sum of width
// S = 32 + log2(MAX_WINDOW), then the divider retires one quotient bit per
// cycle. A fill makes one store write per cycle. A result waiting at the
// output does not block acceptance of the next item, but that item's result
// is held back until the waiting one is taken.
module moving_average_filter #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sma_in_if.sink           i_in,
    sma_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int SW = sma_pkg::DATA_W + $clog2(MAX_WINDOW);
    localparam int CW = (LW > sma_pkg::LEN_REG_W) ? LW : sma_pkg::LEN_REG_W;

    logic [sma_pkg::LEN_REG_W-1:0] r_window_length;
    logic [CW-1:0]                 len_wide;
    logic [LW-1:0]                 eff_len;
    logic                          cfg_write;

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic signed [sma_pkg::DATA_W-1:0] ram_wdata;
    logic                              ram_re;
    logic [AW-1:0]                     ram_raddr;
    logic signed [sma_pkg::DATA_W-1:0] ram_rdata;
    logic                              div_start;
    logic signed [SW-1:0]              div_dividend;
    sma_pkg::t_div_stat                div_stat;
    logic signed [sma_pkg::DATA_W-1:0] div_quot;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == sma_pkg::REG_WINDOW_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= sma_pkg::LEN_RESET;
        end else if (cfg_write) begin
            r_window_length <= pwdata[sma_pkg::LEN_REG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == sma_pkg::REG_WINDOW_LENGTH) begin
            prdata = 32'(r_window_length);
        end
    end

    // clamp the length to 1..MAX_WINDOW
    always_comb begin
        len_wide = CW'(r_window_length);
        if (len_wide == '0) begin
            len_wide = CW'(1);
        end else if (len_wide > CW'(MAX_WINDOW)) begin
            len_wide = CW'(MAX_WINDOW);
        end
        eff_len = LW'(len_wide);
    end

    sma_seq #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_len          (eff_len),
        .i_in           (i_in),
        .o_out          (o_out),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .i_div_stat     (div_stat),
        .i_div_quot     (div_quot)
    );

    sma_ram #(
        .WIDTH(sma_pkg::DATA_W),
        .DEPTH(MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sma_div #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (eff_len),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

endmodule

`default_nettype wire

/* hw/rtl/sma_ram.sv */
`default_nettype none

module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/sma_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. Signed dividend, unsigned
// nonzero divisor, quotient truncated toward zero.
module sma_div #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire logic                                              i_start,
    input  wire logic signed [sma_pkg::DATA_W+$clog2(MAX_WINDOW)-1:0] i_dividend,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]                   i_divisor,
    output sma_pkg::t_div_stat                                     o_stat,
    output logic signed [sma_pkg::DATA_W-1:0]                      o_quot
);

    localparam int SW = sma_pkg::DATA_W + $clog2(MAX_WINDOW);
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int CW = $clog2(SW);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic              r_neg;
    logic [SW-1:0]     r_quo;
    logic [LW-1:0]     r_rem;
    logic [LW-1:0]     r_div;

    logic [LW:0]       rem_sh;
    logic [LW+1:0]     trial;
    logic              ge;
    logic [sma_pkg::DATA_W-1:0] q_mag;

    assign rem_sh = {r_rem, r_quo[SW-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_div};
    assign ge     = ~trial[LW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SW-1];
            r_quo <= i_dividend[SW-1] ? unsigned'(-i_dividend) : unsigned'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SW-2:0], ge};
            r_rem <= ge ? trial[LW-1:0] : rem_sh[LW-1:0];
        end
    end

    assign q_mag       = r_quo[sma_pkg::DATA_W-1:0];
    assign o_quot      = signed'(r_neg ? (~q_mag + sma_pkg::DATA_W'(1)) : q_mag);
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

/* hw/rtl/sma_seq.sv */
`default_nettype none

// Sequencer: clears the store after reset, runs fill sweeps, writes samples,
// reads the window back for the sum and drives the divider and result register.
module sma_seq #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]                   i_len,
    sma_in_if.sink                                                 i_in,
    sma_out_if.source                                              o_out,
    output logic                                                   o_ram_we,
    output logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0]   o_ram_waddr,
    output logic signed [sma_pkg::DATA_W-1:0]                      o_ram_wdata,
    output logic                                                   o_ram_re,
    output logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0]   o_ram_raddr,
    input  wire logic signed [sma_pkg::DATA_W-1:0]                 i_ram_rdata,
    output logic                                                   o_div_start,
    output logic signed [sma_pkg::DATA_W+$clog2(MAX_WINDOW)-1:0]   o_div_dividend,
    input  wire sma_pkg::t_div_stat                                i_div_stat,
    input  wire logic signed [sma_pkg::DATA_W-1:0]                 i_div_quot
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int SW = sma_pkg::DATA_W + $clog2(MAX_WINDOW);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);

    sma_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_pos, n_pos;
    logic [LW-1:0]   r_pnext, n_pnext;
    logic            r_issue_done, n_issue_done;
    logic            r_rd_pend, n_rd_pend;
    logic            r_rd_last, n_rd_last;
    logic            r_out_valid, n_out_valid;
    logic signed [sma_pkg::DATA_W-1:0] r_fill_val, n_fill_val;
    logic signed [sma_pkg::DATA_W-1:0] r_out_avg, n_out_avg;
    logic signed [SW-1:0]              r_acc, n_acc;

    logic                 accept;
    logic                 cnt_last;
    logic                 pnext_ok;
    logic signed [SW-1:0] rdata_ext;

    assign accept    = i_in.valid && i_in.ready;
    assign cnt_last  = (LW'(r_cnt) == (i_len - LW'(1)));
    assign pnext_ok  = (r_pnext < i_len);
    assign rdata_ext = SW'(i_ram_rdata);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_pnext      = r_pnext;
        n_issue_done = r_issue_done;
        n_rd_pend    = r_rd_pend;
        n_rd_last    = r_rd_last;
        n_fill_val   = r_fill_val;
        n_acc        = r_acc;
        n_out_avg    = r_out_avg;
        n_out_valid  = r_out_valid && !o_out.ready;

        o_ram_we       = 1'b0;
        o_ram_waddr    = r_cnt;
        o_ram_wdata    = '0;
        o_ram_re       = 1'b0;
        o_ram_raddr    = r_cnt;
        o_div_start    = 1'b0;
        o_div_dividend = r_acc + rdata_ext;

        // reduce the next write position modulo the length while busy
        if ((r_state == sma_pkg::S_SUM || r_state == sma_pkg::S_DIV ||
             r_state == sma_pkg::S_OUT) && !pnext_ok) begin
            n_pnext = r_pnext - i_len;
        end

        case (r_state)
            sma_pkg::S_CLEAR: begin
                o_ram_we = 1'b1;
                n_cnt    = r_cnt + AW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = sma_pkg::S_IDLE;
                end
            end
            sma_pkg::S_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    if (i_in.operation == sma_pkg::OP_FILL) begin
                        n_fill_val = i_in.value;
                        n_pos      = '0;
                        n_state    = sma_pkg::S_FILL;
                    end else begin
                        o_ram_we     = 1'b1;
                        o_ram_waddr  = r_pos;
                        o_ram_wdata  = i_in.value;
                        n_pnext      = LW'(r_pos) + LW'(1);
                        n_acc        = '0;
                        n_issue_done = 1'b0;
                        n_rd_pend    = 1'b0;
                        n_state      = sma_pkg::S_SUM;
                    end
                end
            end
            sma_pkg::S_FILL: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = r_fill_val;
                n_cnt       = r_cnt + AW'(1);
                if (cnt_last) begin
                    n_state = sma_pkg::S_IDLE;
                end
            end
            sma_pkg::S_SUM: begin
                n_rd_pend = !r_issue_done;
                if (!r_issue_done) begin
                    o_ram_re     = 1'b1;
                    n_cnt        = r_cnt + AW'(1);
                    n_rd_last    = cnt_last;
                    n_issue_done = cnt_last;
                end
                if (r_rd_pend) begin
                    n_acc = r_acc + rdata_ext;
                    if (r_rd_last) begin
                        o_div_start = 1'b1;
                        n_state     = sma_pkg::S_DIV;
                    end
                end
            end
            sma_pkg::S_DIV: begin
                if (i_div_stat.done) begin
                    n_state = sma_pkg::S_OUT;
                end
            end
            sma_pkg::S_OUT: begin
                // hold until the result register is free and the position settled
                if ((!r_out_valid || o_out.ready) && pnext_ok) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = i_div_quot;
                    n_pos       = AW'(r_pnext);
                    n_state     = sma_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sma_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sma_pkg::S_CLEAR;
            r_cnt        <= '0;
            r_pos        <= '0;
            r_pnext      <= '0;
            r_issue_done <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_rd_last    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pos        <= n_pos;
            r_pnext      <= n_pnext;
            r_issue_done <= n_issue_done;
            r_rd_pend    <= n_rd_pend;
            r_rd_last    <= n_rd_last;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_val <= n_fill_val;
        r_acc      <= n_acc;
        r_out_avg  <= n_out_avg;
    end

    assign i_in.ready    = (r_state == sma_pkg::S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.average = r_out_avg;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_stat.done |-> r_state == sma_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_start |-> !i_div_stat.busy)
        else $error("divider started while still busy");

    a_read_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_re |-> LW'(r_cnt) < i_len)
        else $error("store read beyond the window");

    a_no_write_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sma_pkg::S_SUM || r_state == sma_pkg::S_DIV) |-> !o_ram_we)
        else $error("store written while the window sum is formed");

    a_pos_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sma_pkg::S_OUT && n_state == sma_pkg::S_IDLE)
            |=> LW'(r_pos) < i_len)
        else $error("write position left outside the window after a sample");

endmodule

`default_nettype wire
